FILE: rtl/rgs_pkg.sv
// Shared types and constants of the release gain scaler.
package rgs_pkg;

  localparam logic [1:0] REG_SAMPLE_RATE   = 2'd0;
  localparam logic [1:0] REG_SCALED_ENABLE = 2'd1;
  localparam logic [1:0] REG_RELEASE_LIMIT = 2'd2;

  localparam logic [7:0]  KEY_DEFAULT = 8'd60;
  localparam logic [7:0]  KEY_TOP     = 8'd133;
  localparam logic [7:0]  KEY_HIGH    = 8'd96;
  localparam logic [7:0]  KEY_LOW     = 8'd24;
  localparam logic [10:0] ATTACK_LONG  = 11'd2000;
  localparam logic [10:0] ATTACK_SHORT = 11'd200;
  localparam logic [10:0] ATTACK_STEP  = 11'd25;
  localparam logic [8:0]  REV_MIN    = 9'd100;
  localparam logic [8:0]  REV_MAX    = 9'd350;
  localparam logic [5:0]  REV_OFFSET = 6'd40;
  localparam logic [12:0] DECAY_SCALE = 13'd6000;
  localparam logic [9:0]  MS_SCALE    = 10'd1000;
  localparam logic [5:0]  TAIL_SCALE  = 6'd60;

  // One classified release event on its way from the front to the back.
  typedef struct packed {
    logic [31:0]       held;
    logic [15:0]       trunc;
    logic [23:0]       frames;
    logic [17:0]       trate;
    logic              trate_zero;
    logic [17:0]       sr;
    logic [19:0]       base;
    logic [19:0]       vol;
    logic signed [7:0] grp;
    logic              trem;
    logic              none;
    logic [10:0]       a4;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/release_gain_scaler_top.sv
// Top level of the release gain scaler.
//
// The block turns each key-release event into the gain and decay length
// of a release voice. An event beat is taken on a rising edge with start
// high and busy low; all eight event fields are sampled on that edge.
// One result beat leaves for every event, in order, on the result ports
// for exactly one cycle while done is high. The receiver has no way to
// hold results back, and nothing inside the block ever waits on it.
// Throughput is one event per cycle. The path from the accepting edge
// to done runs through the front register, the queue, the back-end
// stages and the two bit-per-stage divider pipelines, one for held time
// and reverb and one for the attack factor and the short-note decay.
// Configuration (sample rate, scaling enable, release limit) is written
// through cfg_we, cfg_index and cfg_data; the user must do so only while
// no event is in flight, as the block does not enforce it.
// Synchronous reset empties the pipeline and the queue, clears done and
// restores the registers to 48000 Hz, scaling on and no release limit.
module release_gain_scaler_top #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [17:0]       cfg_data,
  input  logic [31:0]       held_samples,
  input  logic [7:0]        midi_key,
  input  logic [15:0]       truncation_ms,
  input  logic [23:0]       tail_frames,
  input  logic [17:0]       tail_rate,
  input  logic [19:0]       base_gain,
  input  logic [19:0]       chest_volume,
  input  logic signed [7:0] chest_group,
  output logic              done,
  output logic              create_release,
  output logic [19:0]       release_gain,
  output logic [15:0]       decay_ms,
  output logic signed [7:0] release_group
);

  // Configuration registers.
  logic [17:0] out_rate;
  logic        scaled_enable;
  logic [15:0] release_limit_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_rate         <= 18'd48000;
      scaled_enable    <= 1'b1;
      release_limit_ms <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        rgs_pkg::REG_SAMPLE_RATE:   out_rate         <= cfg_data;
        rgs_pkg::REG_SCALED_ENABLE: scaled_enable    <= cfg_data[0];
        rgs_pkg::REG_RELEASE_LIMIT: release_limit_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  rgs_pkg::item_t   f_item;
  logic             f_valid;
  rgs_pkg::item_t   q_item;
  rgs_pkg::q_stat_t q_stat;
  logic             take;

  // The back end drains one beat per cycle, so the queue never fills and
  // busy only guards the case in principle.
  assign busy = q_stat.full;
  assign take = start && !busy;

  rgs_front u_front (
    .clk, .rst, .take, .out_rate,
    .held_samples, .midi_key, .truncation_ms, .tail_frames, .tail_rate,
    .base_gain, .chest_volume, .chest_group,
    .item_valid(f_valid), .item(f_item)
  );

  rgs_queue u_queue (
    .clk, .rst, .push(f_valid), .wr_item(f_item), .pop(!q_stat.empty),
    .rd_item(q_item), .stat(q_stat)
  );

  rgs_back #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_back (
    .clk, .rst, .in_valid(!q_stat.empty), .item(q_item),
    .scaled_enable, .release_limit_ms,
    .done, .create_release, .release_gain, .decay_ms, .release_group
  );

  // A result without a release voice carries all zero fields.
  assert property (@(posedge clk) disable iff (rst)
    done && !create_release |->
      release_gain == 20'd0 && decay_ms == 16'd0 && release_group == 8'sd0)
    else $error("no-release result with nonzero fields");

  // Only a tremulant group is passed on.
  assert property (@(posedge clk) disable iff (rst)
    done && release_group != 8'sd0 |-> release_group[7] && create_release)
    else $error("regular chest passed its group on");

  // The back end keeps pace, so the front is never held off.
  assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("queue filled up");

endmodule

FILE: rtl/rgs_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
module rgs_div #(
  parameter int NW = 42,
  parameter int DW = 18,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [NW-1:0] quot,
  output logic [TW-1:0] tag_out
);

  logic [NW-1:0] nr   [NW+1];
  logic [NW-1:0] qr   [NW+1];
  logic [DW-1:0] rem  [NW+1];
  logic [DW-1:0] dr   [NW+1];
  logic [TW-1:0] tr   [NW+1];
  logic          vr   [NW+1];

  assign nr[0]  = num;
  assign qr[0]  = '0;
  assign rem[0] = '0;
  assign dr[0]  = den;
  assign tr[0]  = tag_in;
  assign vr[0]  = in_valid;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    logic [DW:0] diff;
    assign trial = {rem[k], nr[k][NW-1]};
    assign ge    = trial >= {1'b0, dr[k]};
    assign diff  = trial - {1'b0, dr[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[k+1] <= 1'b0;
      end else begin
        vr[k+1] <= vr[k];
      end
      rem[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      nr[k+1]  <= nr[k] << 1;
      qr[k+1]  <= {qr[k][NW-2:0], ge};
      dr[k+1]  <= dr[k];
      tr[k+1]  <= tr[k];
    end
  end

  assign out_valid = vr[NW];
  assign quot      = qr[NW];
  assign tag_out   = tr[NW];

endmodule

FILE: rtl/rgs_front.sv
// Front end: takes a release event and classifies it.
module rgs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [17:0]       out_rate,
  input  logic [31:0]       held_samples,
  input  logic [7:0]        midi_key,
  input  logic [15:0]       truncation_ms,
  input  logic [23:0]       tail_frames,
  input  logic [17:0]       tail_rate,
  input  logic [19:0]       base_gain,
  input  logic [19:0]       chest_volume,
  input  logic signed [7:0] chest_group,
  output logic              item_valid,
  output rgs_pkg::item_t    item
);

  logic [7:0]     key_eff;
  logic [10:0]    a4;
  rgs_pkg::item_t item_next;

  always_comb begin
    key_eff = midi_key;
    if (midi_key > rgs_pkg::KEY_TOP || midi_key == 8'd0) begin
      key_eff = rgs_pkg::KEY_DEFAULT;
    end
    if (key_eff >= rgs_pkg::KEY_HIGH) begin
      a4 = rgs_pkg::ATTACK_SHORT;
    end else if (key_eff < rgs_pkg::KEY_LOW) begin
      a4 = rgs_pkg::ATTACK_LONG;
    end else begin
      a4 = rgs_pkg::ATTACK_LONG
           - rgs_pkg::ATTACK_STEP * {3'b0, key_eff - rgs_pkg::KEY_LOW};
    end
    item_next.held       = held_samples;
    item_next.trunc      = truncation_ms;
    item_next.frames     = tail_frames;
    item_next.trate      = tail_rate;
    item_next.trate_zero = tail_rate == 18'd0;
    item_next.sr         = (out_rate == 18'd0) ? 18'd1 : out_rate;
    item_next.base       = base_gain;
    item_next.vol        = chest_volume;
    item_next.grp        = chest_group;
    item_next.trem       = chest_group[7];
    item_next.none       = !chest_group[7] && chest_volume == 20'd0;
    item_next.a4         = a4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= take;
    end
    if (take) begin
      item <= item_next;
    end
  end

endmodule

FILE: rtl/rgs_queue.sv
// Two-entry queue between the front end and the arithmetic back end.
module rgs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rgs_pkg::item_t   wr_item,
  input  logic             pop,
  output rgs_pkg::item_t   rd_item,
  output rgs_pkg::q_stat_t stat
);

  rgs_pkg::item_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign stat.full  = count == 2'd2;
  assign stat.empty = count == 2'd0;
  assign rd_item    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
    stat.empty && !push |=> stat.empty)
    else $error("queue filled without a push");
  assert property (@(posedge clk) disable iff (rst)
    push && !pop && !stat.full |=> !stat.empty)
    else $error("pushed beat lost");

endmodule

FILE: rtl/rgs_back.sv
// Back end: divider pipelines for held time, reverb, gain scaling and decay.
module rgs_back #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rgs_pkg::item_t    item,
  input  logic              scaled_enable,
  input  logic [15:0]       release_limit_ms,
  output logic              done,
  output logic              create_release,
  output logic [19:0]       release_gain,
  output logic [15:0]       decay_ms,
  output logic signed [7:0] release_group
);

  localparam int GW = (40 - GAIN_FRAC_BITS > 20) ? 40 - GAIN_FRAC_BITS : 20;
  localparam int NB = GW + 25;

  typedef struct packed {
    logic [19:0]       base;
    logic [19:0]       vol;
    logic signed [7:0] grp;
    logic              trem;
    logic              none;
    logic [10:0]       a4;
  } a_tag_t;

  typedef struct packed {
    logic [15:0] trunc;
    logic        trate_zero;
  } r_tag_t;

  typedef struct packed {
    logic [GW-1:0]     gain_c;
    logic              ms_lt_a;
    logic              trem;
    logic              none;
    logic signed [7:0] grp;
  } g_tag_t;

  typedef struct packed {
    logic [8:0]  rev;
    logic        ms_lt_rev;
    logic [15:0] trunc;
  } d_tag_t;

  // Stage 0: dividends and divisors.
  logic          v0;
  logic [41:0]   n_ms;
  logic [41:0]   n_rev;
  logic [17:0]   d_ms;
  logic [17:0]   d_rev;
  a_tag_t        ta0;
  r_tag_t        tr0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
    n_ms  <= {10'b0, item.held} * {32'b0, rgs_pkg::MS_SCALE};
    n_rev <= {12'b0, 30'({6'b0, item.frames} * {24'b0, rgs_pkg::TAIL_SCALE})};
    d_ms  <= item.sr;
    d_rev <= item.trate_zero ? 18'd1 : item.trate;
    ta0   <= '{base: item.base, vol: item.vol, grp: item.grp, trem: item.trem,
               none: item.none, a4: item.a4};
    tr0   <= '{trunc: item.trunc, trate_zero: item.trate_zero};
  end

  logic        va;
  logic        va_unused;
  logic [41:0] q_ms;
  logic [41:0] q_rev;
  a_tag_t      ta;
  r_tag_t      tra;

  rgs_div #(.NW(42), .DW(18), .TW($bits(a_tag_t))) u_div_ms (
    .clk, .rst, .in_valid(v0), .num(n_ms), .den(d_ms), .tag_in(ta0),
    .out_valid(va), .quot(q_ms), .tag_out(ta)
  );

  rgs_div #(.NW(42), .DW(18), .TW($bits(r_tag_t))) u_div_rev (
    .clk, .rst, .in_valid(v0), .num(n_rev), .den(d_rev), .tag_in(tr0),
    .out_valid(va_unused), .quot(q_rev), .tag_out(tra)
  );

  // Stage 1: held time compares, reverb clamp, chest gain product.
  logic [41:0] rev_raw;
  logic [8:0]  rev_next;
  logic        v1;
  logic [39:0] prod1;
  logic        ms_lt_a1;
  logic        ms_small1;
  logic [8:0]  ms_lo1;
  logic [8:0]  rev1;
  a_tag_t      t1;
  logic [15:0] trunc1;

  always_comb begin
    if (tra.trunc != 16'd0) begin
      rev_raw = {26'b0, tra.trunc};
    end else if (tra.trate_zero) begin
      rev_raw = {33'b0, rgs_pkg::REV_MAX};
    end else begin
      rev_raw = q_rev + {36'b0, rgs_pkg::REV_OFFSET};
    end
    if (rev_raw > {33'b0, rgs_pkg::REV_MAX}) begin
      rev_next = rgs_pkg::REV_MAX;
    end else if (rev_raw < {33'b0, rgs_pkg::REV_MIN}) begin
      rev_next = rgs_pkg::REV_MIN;
    end else begin
      rev_next = rev_raw[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= va && va_unused;
    end
    prod1     <= {20'b0, ta.base} * {20'b0, ta.vol};
    ms_lt_a1  <= q_ms < {33'b0, ta.a4[10:2]};
    ms_small1 <= q_ms < 42'd512;
    ms_lo1    <= q_ms[8:0];
    rev1      <= rev_next;
    t1        <= ta;
    trunc1    <= tra.trunc;
  end

  // Stage 2: squared attack, t and (2A - t), decay dividend.
  logic          v2;
  logic [GW-1:0] gain_c2;
  logic [21:0]   a_sq2;
  logic [10:0]   t2;
  logic [11:0]   d2;
  logic [21:0]   dnum2;
  logic          ms_lt_a2;
  logic          ms_lt_rev2;
  logic [8:0]    rev2;
  logic [15:0]   trunc2;
  logic          trem2;
  logic          none2;
  logic signed [7:0] grp2;
  logic [39:0]   prod_shift;

  assign prod_shift = prod1 >> GAIN_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    gain_c2    <= t1.trem ? GW'(t1.base) : prod_shift[GW-1:0];
    a_sq2      <= {11'b0, t1.a4} * {11'b0, t1.a4};
    t2         <= {ms_lo1, 2'b00};
    d2         <= {t1.a4, 1'b0} - {1'b0, ms_lo1, 2'b00};
    dnum2      <= {13'b0, ms_lo1} * {9'b0, rgs_pkg::DECAY_SCALE};
    ms_lt_a2   <= ms_lt_a1;
    ms_lt_rev2 <= ms_small1 && (ms_lo1 < rev1);
    rev2       <= rev1;
    trunc2     <= trunc1;
    trem2      <= t1.trem;
    none2      <= t1.none;
    grp2       <= t1.grp;
  end

  // Stages 3 to 5: numerator of the quadratic factor, then gain product.
  logic          v3, v4, v5;
  logic [22:0]   m3;
  logic [24:0]   den3, den4, den5;
  logic [21:0]   a_sq3;
  logic [24:0]   num4;
  logic [NB-1:0] prod5;
  g_tag_t        tg3, tg4, tg5;
  d_tag_t        td3, td4, td5;
  logic [21:0]   dnum3, dnum4, dnum5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
    m3    <= {12'b0, t2} * {11'b0, d2};
    den3  <= {3'b0, a_sq2} * 25'd5;
    a_sq3 <= a_sq2;
    tg3   <= '{gain_c: gain_c2, ms_lt_a: ms_lt_a2, trem: trem2, none: none2,
               grp: grp2};
    td3   <= '{rev: rev2, ms_lt_rev: ms_lt_rev2, trunc: trunc2};
    dnum3 <= dnum2;

    num4  <= {3'b0, a_sq3} + {m3, 2'b00};
    den4  <= den3;
    tg4   <= tg3;
    td4   <= td3;
    dnum4 <= dnum3;

    prod5 <= NB'(tg4.gain_c) * NB'(num4);
    den5  <= den4;
    tg5   <= tg4;
    td5   <= td4;
    dnum5 <= dnum4;
  end

  logic          vb;
  logic          vb_unused;
  logic [NB-1:0] q_gain;
  logic [NB-1:0] q_dec;
  g_tag_t        tgb;
  d_tag_t        tdb;

  rgs_div #(.NW(NB), .DW(25), .TW($bits(g_tag_t))) u_div_gain (
    .clk, .rst, .in_valid(v5), .num(prod5), .den(den5), .tag_in(tg5),
    .out_valid(vb), .quot(q_gain), .tag_out(tgb)
  );

  rgs_div #(.NW(NB), .DW(9), .TW($bits(d_tag_t))) u_div_decay (
    .clk, .rst, .in_valid(v5), .num(NB'(dnum5)), .den(td5.rev), .tag_in(td5),
    .out_valid(vb_unused), .quot(q_dec), .tag_out(tdb)
  );

  // Final stage: select, limit, saturate.
  logic          scale;
  logic [NB-1:0] gain_sel;
  logic [15:0]   decay_sel;
  logic [15:0]   decay_fin;

  always_comb begin
    scale    = !tgb.trem && scaled_enable;
    gain_sel = (scale && tgb.ms_lt_a) ? q_gain : NB'(tgb.gain_c);
    decay_sel = (scale && tdb.ms_lt_rev) ? 16'(tdb.rev) + q_dec[15:0] : 16'd0;
    decay_fin = decay_sel;
    if (release_limit_ms != 16'd0) begin
      if (release_limit_ms < decay_sel || decay_sel == 16'd0) begin
        decay_fin = release_limit_ms;
      end
    end else if (tdb.trunc != 16'd0 && decay_sel == 16'd0) begin
      decay_fin = tdb.trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vb && vb_unused;
    end
    if (tgb.none) begin
      create_release <= 1'b0;
      release_gain   <= 20'd0;
      decay_ms       <= 16'd0;
      release_group  <= 8'sd0;
    end else begin
      create_release <= 1'b1;
      release_gain   <= (gain_sel > NB'(20'hFFFFF)) ? 20'hFFFFF : gain_sel[19:0];
      decay_ms       <= decay_fin;
      release_group  <= tgb.trem ? tgb.grp : 8'sd0;
    end
  end

endmodule

FILE: verif/release_gain_scaler_top_tb.sv
// Self-checking testbench of the release gain scaler: directed and random events checked by a predictor.
`timescale 1ns / 100ps

module release_gain_scaler_top_tb;

  localparam int GAIN_FRAC_BITS = 16;
  localparam int SETTLE_CYCLES = 130;
  localparam logic [19:0] GAIN_SAT = 20'hFFFFF;

  // One key-release event as driven onto the event ports.
  typedef struct packed {
    logic [31:0]       held;
    logic [7:0]        key;
    logic [15:0]       trunc;
    logic [23:0]       frames;
    logic [17:0]       trate;
    logic [19:0]       base;
    logic [19:0]       vol;
    logic signed [7:0] grp;
  } release_event_t;

  // The release voice settings that one event yields.
  typedef struct packed {
    logic              create;
    logic [19:0]       gain;
    logic [15:0]       decay;
    logic signed [7:0] group;
  } release_voice_t;

  // A directed row: the event and, where it is obvious, the voice typed in by hand.
  typedef struct packed {
    release_event_t ev;
    logic           typed;
    release_voice_t voice;
  } directed_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = rgs_pkg::REG_SAMPLE_RATE;
  logic [17:0]       cfg_data = '0;
  logic [31:0]       held_samples = '0;
  logic [7:0]        midi_key = '0;
  logic [15:0]       truncation_ms = '0;
  logic [23:0]       tail_frames = '0;
  logic [17:0]       tail_rate = '0;
  logic [19:0]       base_gain = '0;
  logic [19:0]       chest_volume = '0;
  logic signed [7:0] chest_group = '0;
  logic              done;
  logic              create_release;
  logic [19:0]       release_gain;
  logic [15:0]       decay_ms;
  logic signed [7:0] release_group;

  // Shadow copy of the configuration registers.
  logic [17:0] rate_hz;
  logic        scaling_on;
  logic [15:0] limit_ms;

  release_voice_t pending_voices[$];
  directed_row_t  directed_rows[$];
  int             mismatches = 0;
  int             idle_pct = 0;

  release_gain_scaler_top #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .held_samples(held_samples), .midi_key(midi_key), .truncation_ms(truncation_ms),
    .tail_frames(tail_frames), .tail_rate(tail_rate), .base_gain(base_gain),
    .chest_volume(chest_volume), .chest_group(chest_group),
    .done(done), .create_release(create_release), .release_gain(release_gain),
    .decay_ms(decay_ms), .release_group(release_group)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Works out the release voice of one event under the current register settings.
  function automatic release_voice_t predict_release(input release_event_t ev);
    release_voice_t v;
    logic [63:0]    gain, decay, sr, held_ms, k, a4, t, num, rev;
    logic           trem;
    v = '0;
    decay = 0;
    trem = ev.grp[7];
    // A regular chest with zero volume gets no release at all.
    if (!trem && ev.vol == 0) return v;
    if (trem) gain = 64'(ev.base);
    else gain = (64'(ev.base) * 64'(ev.vol)) >> GAIN_FRAC_BITS;
    if (!trem && scaling_on) begin
      sr = (rate_hz == 0) ? 64'd1 : 64'(rate_hz);
      held_ms = 64'(ev.held) * 1000 / sr;
      k = 64'(ev.key);
      if (k > 133 || k == 0) k = 60;
      if (k >= 96) a4 = 200;
      else if (k < 24) a4 = 2000;
      else a4 = 2000 - 25 * (k - 24);
      // Released inside the attack: the quadratic factor runs from 0.2 up to 1.
      if (held_ms < a4 / 4) begin
        t = 4 * held_ms;
        num = a4 * a4 + 4 * t * (2 * a4 - t);
        gain = gain * num / (5 * a4 * a4);
      end
      if (ev.trunc != 0) rev = 64'(ev.trunc);
      else if (ev.trate == 0) rev = 350;
      else rev = (60 * 64'(ev.frames)) / 64'(ev.trate) + 40;
      if (rev > 350) rev = 350;
      if (rev < 100) rev = 100;
      if (held_ms < rev) decay = rev + 6000 * held_ms / rev;
    end
    // The global limit wins over both a missing and a longer decay.
    if (limit_ms != 0) begin
      if (64'(limit_ms) < decay || decay == 0) decay = 64'(limit_ms);
    end else if (ev.trunc != 0 && decay == 0) begin
      decay = 64'(ev.trunc);
    end
    if (gain > 64'(GAIN_SAT)) gain = 64'(GAIN_SAT);
    if (decay > 64'hFFFF) decay = 64'hFFFF;
    v.create = 1'b1;
    v.gain = gain[19:0];
    v.decay = decay[15:0];
    v.group = trem ? ev.grp : 8'sd0;
    return v;
  endfunction

  // Random event, weighted toward short holds and real reverb times so that
  // the attack scaling and the short-note decay are reached often.
  function automatic release_event_t random_event();
    release_event_t ev;
    ev.held = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 40000)) : $urandom;
    ev.key = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0, 1: ev.trunc = '0;
      2: ev.trunc = 16'($urandom_range(1, 400));
      default: ev.trunc = 16'($urandom);
    endcase
    ev.frames = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 600000)) : 24'($urandom);
    case ($urandom_range(0, 9))
      0: ev.trate = '0;
      1: ev.trate = 18'($urandom);
      default: ev.trate = 18'($urandom_range(8000, 192000));
    endcase
    ev.base = 20'($urandom);
    ev.vol = ($urandom_range(0, 9) == 0) ? 20'd0 : 20'($urandom);
    ev.grp = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255)) : 8'($urandom);
    return ev;
  endfunction

  // Offers one event beat and returns after the edge that accepts it.
  task automatic send_event(input release_event_t ev, input logic typed,
                            input release_voice_t voice);
    int gap;
    if ($urandom_range(1, 100) <= idle_pct) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    held_samples <= ev.held;
    midi_key <= ev.key;
    truncation_ms <= ev.trunc;
    tail_frames <= ev.frames;
    tail_rate <= ev.trate;
    base_gain <= ev.base;
    chest_volume <= ev.vol;
    chest_group <= ev.grp;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_voices.insert(pending_voices.size(), typed ? voice : predict_release(ev));
  endtask

  // Waits until every voice has come out and the pipe is drained, then writes a register.
  task automatic write_reg(input logic [1:0] idx, input logic [17:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending_voices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rgs_pkg::REG_SAMPLE_RATE: rate_hz = value;
      rgs_pkg::REG_SCALED_ENABLE: scaling_on = value[0];
      default: limit_ms = value[15:0];
    endcase
  endtask

  task automatic add_row(input release_event_t ev, input logic typed,
                         input release_voice_t voice);
    directed_row_t row;
    row.ev = ev;
    row.typed = typed;
    row.voice = voice;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Result beats are taken at every edge where done was high in the cycle before.
  always @(posedge clk) begin
    release_voice_t want;
    if (!rst && done) begin
      if (pending_voices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        want = pending_voices.pop_front();
        if (create_release !== want.create || release_gain !== want.gain ||
            decay_ms !== want.decay || release_group !== want.group) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected create %0d gain %h decay %0d group %0d, got create %0d gain %h decay %0d group %0d",
                     $realtime, want.create, want.gain, want.decay, want.group,
                     create_release, release_gain, decay_ms, release_group);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("release_gain_scaler_top test failed");
    $finish;
  end

  initial begin
    release_event_t ev;
    release_voice_t none_voice, v;
    int phase_idle[4];
    none_voice = '0;
    rate_hz = 18'd48000;
    scaling_on = 1'b1;
    limit_ms = '0;
    phase_idle[0] = 0;
    phase_idle[1] = 87;
    phase_idle[2] = 0;
    phase_idle[3] = 32;

    // Zero chest volume on a regular chest: no release.
    ev = '{held: 32'd100, key: 8'd60, trunc: 16'd0, frames: 24'd48000, trate: 18'd48000,
           base: 20'hFFFFF, vol: 20'd0, grp: 8'sd3};
    add_row(ev, 1'b1, none_voice);
    // Tremulant: gain passes unscaled, no decay, the group comes back.
    ev = '{held: 32'd0, key: 8'd0, trunc: 16'd0, frames: 24'hFFFFFF, trate: 18'h3FFFF,
           base: 20'h12345, vol: 20'd0, grp: -8'sd128};
    v = '{create: 1'b1, gain: 20'h12345, decay: 16'd0, group: -8'sd128};
    add_row(ev, 1'b1, v);
    // Long hold with both gains at full scale: the product saturates.
    ev = '{held: 32'hFFFFFFFF, key: 8'd255, trunc: 16'd0, frames: 24'd0, trate: 18'd48000,
           base: 20'hFFFFF, vol: 20'hFFFFF, grp: 8'sd127};
    v = '{create: 1'b1, gain: GAIN_SAT, decay: 16'd0, group: 8'sd0};
    add_row(ev, 1'b1, v);
    // Key boundaries: zero, below 24, the sloped range, 96 and up, past 133.
    for (int i = 0; i < 9; i++) begin
      ev = '{held: 32'(i * 700), key: 8'd0, trunc: 16'd0, frames: 24'(i * 50000),
             trate: 18'd44100, base: 20'h10000, vol: 20'h10000, grp: 8'sd0};
      case (i)
        0: ev.key = 8'd0;
        1: ev.key = 8'd23;
        2: ev.key = 8'd24;
        3: ev.key = 8'd95;
        4: ev.key = 8'd96;
        5: ev.key = 8'd133;
        6: ev.key = 8'd134;
        7: ev.key = 8'd255;
        default: ev.key = 8'd1;
      endcase
      add_row(ev, 1'b0, none_voice);
    end
    // Reverb time: zero tail rate, truncation given, clamps at both ends.
    ev = '{held: 32'd2400, key: 8'd60, trunc: 16'd0, frames: 24'd1000, trate: 18'd0,
           base: 20'h08000, vol: 20'h20000, grp: 8'sd0};
    add_row(ev, 1'b0, none_voice);
    ev.trunc = 16'd200;
    add_row(ev, 1'b0, none_voice);
    ev.trunc = 16'hFFFF;
    add_row(ev, 1'b0, none_voice);
    ev.trunc = 16'd0;
    ev.trate = 18'd8000;
    add_row(ev, 1'b0, none_voice);
    ev.frames = 24'hFFFFFF;
    add_row(ev, 1'b0, none_voice);
    // Truncation standing in for a missing decay after a long hold.
    ev.held = 32'd4800000;
    ev.trunc = 16'd777;
    add_row(ev, 1'b0, none_voice);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].voice);

    // Random part in four phases, each under its own register settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(rgs_pkg::REG_SAMPLE_RATE, 18'd8000);
          write_reg(rgs_pkg::REG_RELEASE_LIMIT, 18'd65535);
        end
        1: begin
          write_reg(rgs_pkg::REG_SAMPLE_RATE, 18'd192000);
          write_reg(rgs_pkg::REG_SCALED_ENABLE, 18'd0);
          write_reg(rgs_pkg::REG_RELEASE_LIMIT, 18'd300);
        end
        2: begin
          write_reg(rgs_pkg::REG_SAMPLE_RATE, 18'd0);
          write_reg(rgs_pkg::REG_SCALED_ENABLE, 18'd1);
          write_reg(rgs_pkg::REG_RELEASE_LIMIT, 18'($urandom_range(1, 2000)));
        end
        default: begin
          write_reg(rgs_pkg::REG_SAMPLE_RATE, 18'h3FFFF);
          write_reg(rgs_pkg::REG_RELEASE_LIMIT, 18'd0);
        end
      endcase
      idle_pct = phase_idle[ph];
      for (int n = 0; n < 200; n++) send_event(random_event(), 1'b0, none_voice);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_voices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("release_gain_scaler_top test passed");
    end else begin
      $display("release_gain_scaler_top test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rgs_pkg.sv
rtl/rgs_div.sv
rtl/rgs_front.sv
rtl/rgs_queue.sv
rtl/rgs_back.sv
rtl/release_gain_scaler_top.sv
verif/release_gain_scaler_top_tb.sv
